FILE: rtl/core/tdpt_pkg.sv
// shared types and defaults for the trial division prime table
// used by tdpt_ctrl, tdpt_datapath and trial_division_prime_table
package tdpt_pkg;

    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int CAND_WIDTH       = 32;   // width of the candidate field on the input

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } tdpt_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic start_div;
        logic div_step;
        logic next_idx;
        logic set_bound;
        logic set_divided;
        logic finish;
    } tdpt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cand_small;
        logic idx_at_end;
        logic prime_over;
        logic div_last;
        logic rem_zero;
        logic out_busy;
    } tdpt_status_t;

endpackage

FILE: rtl/core/trial_division_prime_table.sv
// top level of the trial division prime table
// depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath
//
//   channel  | direction | tdata (low bit up)                                | tuser/tlast
//   s_axis   | in        | candidate[31:0]                                   | none
//   m_axis   | out       | is_prime, appended, incomplete, table_count[12:0] | none
//
// one candidate at a time; each stored prime tried passes through a table read, a bound
// compare, a bit-serial remainder and a check of the remainder
// a new candidate is taken while the previous result still waits on m_axis
// reset restores the table to the single prime two; no clearing pass is needed
module trial_division_prime_table
    import tdpt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_W = ((3 + CNT_W + 7) / 8) * 8
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CAND_WIDTH-1:0] s_axis_tdata,   // candidate
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // is_prime, appended, incomplete, table_count
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdpt_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: rtl/core/tdpt_ctrl.sv
// sequencer for the trial division loop: fetch a prime, divide, decide
// depends on tdpt_pkg for the state, command and status types
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  tdpt_status_t status,
    output tdpt_cmd_t    cmd
);

    tdpt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // below two, or every stored prime tried
                if (status.cand_small || status.idx_at_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.prime_over) begin
                    cmd.set_bound = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.rem_zero) begin
                    cmd.set_divided = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tdpt_datapath.sv
// prime table memory, bit-serial remainder unit and result register
// depends on tdpt_pkg for command and status types
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_W = ((3 + CNT_W + 7) / 8) * 8
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CAND_WIDTH-1:0] in_data,
    input  tdpt_cmd_t             cmd,
    output tdpt_status_t          status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      out_data
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int STEP_W = $clog2(NUMBER_WIDTH);

    logic [NUMBER_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [CAND_WIDTH+NUMBER_WIDTH-1:0] in_ext;
    logic [NUMBER_WIDTH-1:0] cand_reg;
    logic [NUMBER_WIDTH-1:0] half;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [NUMBER_WIDTH-1:0] last_prime_reg, last_prime_next;
    logic                    divided_reg;
    logic                    bound_reg;

    logic [NUMBER_WIDTH-1:0] rd_data_reg;
    logic                    rd_first_reg;
    logic [NUMBER_WIDTH-1:0] prime;

    logic [NUMBER_WIDTH-1:0] divisor_reg;
    logic [NUMBER_WIDTH-1:0] shift_reg;
    logic [NUMBER_WIDTH-1:0] rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [NUMBER_WIDTH:0]   rem_shift;
    logic [NUMBER_WIDTH:0]   rem_sub;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_data_reg;

    logic                    cand_small;
    logic                    is_prime;
    logic                    incomplete;
    logic                    append;

    // candidate reduced or zero-extended to the working width
    assign in_ext     = {{NUMBER_WIDTH{1'b0}}, in_data};
    assign half       = cand_reg >> 1;
    assign cand_small = (cand_reg < NUMBER_WIDTH'(2));

    // entry 0 is the fixed prime two and is never held in the array
    assign prime = rd_first_reg ? NUMBER_WIDTH'(2) : rd_data_reg;

    // one restoring step of the remainder
    assign rem_shift = {rem_reg, shift_reg[NUMBER_WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    assign is_prime   = !cand_small && !divided_reg;
    assign incomplete = is_prime && !bound_reg;
    assign append     = is_prime && bound_reg && (count_reg < CNT_W'(TABLE_DEPTH))
                        && (cand_reg > last_prime_reg);

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[idx_reg[IDX_W-1:0]];
            rd_first_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && append) begin
            mem[count_reg[IDX_W-1:0]] <= cand_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg    <= in_ext[NUMBER_WIDTH-1:0];
            idx_reg     <= '0;
            divided_reg <= 1'b0;
            bound_reg   <= 1'b0;
        end else begin
            if (cmd.next_idx) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.set_bound) begin
                bound_reg <= 1'b1;
            end
            if (cmd.set_divided) begin
                divided_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            divisor_reg <= prime;
            shift_reg   <= cand_reg;
            rem_reg     <= '0;
            step_reg    <= STEP_W'(NUMBER_WIDTH - 1);
        end else if (cmd.div_step) begin
            shift_reg <= shift_reg << 1;
            step_reg  <= step_reg - STEP_W'(1);
            if (!rem_sub[NUMBER_WIDTH]) begin
                rem_reg <= rem_sub[NUMBER_WIDTH-1:0];
            end else begin
                rem_reg <= rem_shift[NUMBER_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        count_next      = count_reg;
        last_prime_next = last_prime_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            out_valid_next = 1'b1;
            if (append) begin
                count_next      = count_reg + CNT_W'(1);
                last_prime_next = cand_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= CNT_W'(1);
            last_prime_reg <= NUMBER_WIDTH'(2);
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            last_prime_reg <= last_prime_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= OUT_W'({count_next, incomplete, append, is_prime});
        end
    end

    assign status.cand_small = cand_small;
    assign status.idx_at_end = (idx_reg == count_reg);
    assign status.prime_over = (prime == '0) || (prime > half);
    assign status.div_last   = (step_reg == '0);
    assign status.rem_zero   = (rem_reg == '0);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
